@@ hw/rtl/pai_pkg.sv @@
// Shared types and codes for the two-objective non-dominated archive.
// Used by pai_cmp, pai_seq, the top level pareto_archive_insert_unit and the bench.
package pai_pkg;

    localparam int REQ_BITS    = 2;
    localparam int STATUS_BITS = 2;
    localparam int INDEX_BITS  = 8;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_INSERT = 2'd0,
        REQ_TEST   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_DOMINATED = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef struct packed {
        logic worse;
        logic covered;
    } cmp_res_t;

endpackage

@@ hw/rtl/pai_mem.sv @@
// Archive storage: one write port and one read port with registered read data.
// Each word holds both objectives of one point. No package dependency.
module pai_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 48
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/pai_cmp.sv @@
// Dominance compare unit shared by every scan step.
// Depends on pai_pkg for the compare result struct.
module pai_cmp #(
    parameter int OBJ_BITS = 24
) (
    input  logic [OBJ_BITS-1:0] point_one,
    input  logic [OBJ_BITS-1:0] point_two,
    input  logic [OBJ_BITS-1:0] entry_one,
    input  logic [OBJ_BITS-1:0] entry_two,
    output pai_pkg::cmp_res_t   res
);
    import pai_pkg::*;

    // The entry is worse when the point beats it on both objectives, and it
    // covers the point when it is at least as good on both.
    assign res.worse   = (point_one > entry_one) && (point_two > entry_two);
    assign res.covered = (point_one <= entry_one) && (point_two <= entry_two);

endmodule

@@ hw/rtl/pai_seq.sv @@
// Request sequencer: scans, compacts, appends and reads archive entries through the
// memory and the shared compare unit, and clears the archive. Depends on pai_pkg.
module pai_seq #(
    parameter int CAPACITY = 256,
    parameter int OBJ_BITS = 24,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    output logic                                idle,
    input  pai_pkg::req_t                       req,
    input  logic [OBJ_BITS-1:0]                 obj_one,
    input  logic [OBJ_BITS-1:0]                 obj_two,
    input  logic [pai_pkg::INDEX_BITS-1:0]      read_index,
    output logic [OBJ_BITS-1:0]                 point_one,
    output logic [OBJ_BITS-1:0]                 point_two,
    input  pai_pkg::cmp_res_t                   cmp,
    output logic                                wr_en,
    output logic [AW-1:0]                       wr_addr,
    output logic [2*OBJ_BITS-1:0]               wr_data,
    output logic [AW-1:0]                       rd_addr,
    input  logic [2*OBJ_BITS-1:0]               rd_data,
    output logic                                res_valid,
    input  logic                                res_ready,
    output pai_pkg::status_t                    res_status,
    output logic [CW-1:0]                       res_count,
    output logic [CW-1:0]                       res_removed,
    output logic [OBJ_BITS-1:0]                 res_one,
    output logic [OBJ_BITS-1:0]                 res_two
);
    import pai_pkg::*;

    localparam int IW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RD     = 7'b0000010,
        S_CMP    = 7'b0000100,
        S_MOVE   = 7'b0001000,
        S_APPEND = 7'b0010000,
        S_FETCH  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic [OBJ_BITS-1:0] a_reg, a_next;
    logic [OBJ_BITS-1:0] b_reg, b_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [CW-1:0]       size_reg, size_next;
    logic [CW-1:0]       removed_reg, removed_next;
    status_t             status_reg, status_next;
    logic [OBJ_BITS-1:0] e1_reg, e1_next;
    logic [OBJ_BITS-1:0] e2_reg, e2_next;

    logic [IW-1:0] idx_wide;
    logic [IW-1:0] size_wide;
    logic [CW-1:0] j_inc;
    logic [CW-1:0] last_pos;

    assign idx_wide  = IW'(read_index);
    assign size_wide = IW'(size_reg);
    assign j_inc     = j_reg + ONE_C;
    assign last_pos  = size_reg - ONE_C;

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        j_next       = j_reg;
        size_next    = size_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        e1_next      = e1_reg;
        e2_next      = e2_reg;
        rd_addr      = j_reg[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = j_reg[AW-1:0];
        wr_data      = rd_data;
        res_valid    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    req_next     = req;
                    a_next       = obj_one;
                    b_next       = obj_two;
                    j_next       = '0;
                    removed_next = '0;
                    status_next  = ST_OK;
                    e1_next      = '0;
                    e2_next      = '0;
                    case (req)
                        REQ_INSERT, REQ_TEST: begin
                            state_next = S_RD;
                        end
                        REQ_CLEAR: begin
                            size_next  = '0;
                            state_next = S_DONE;
                        end
                        default: begin
                            if (idx_wide < size_wide) begin
                                rd_addr    = idx_wide[AW-1:0];
                                state_next = S_FETCH;
                            end else begin
                                status_next = ST_BAD_INDEX;
                                state_next  = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                if (j_reg >= size_reg) begin
                    state_next = (req_reg == REQ_INSERT) ? S_APPEND : S_DONE;
                end else begin
                    rd_addr    = j_reg[AW-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if ((req_reg == REQ_INSERT) && cmp.worse) begin
                    rd_addr    = last_pos[AW-1:0];
                    state_next = S_MOVE;
                end else if (cmp.covered) begin
                    status_next = ST_DOMINATED;
                    state_next  = S_DONE;
                end else begin
                    j_next = j_inc;
                    if (j_inc < size_reg) begin
                        rd_addr = j_inc[AW-1:0];
                    end else begin
                        state_next = (req_reg == REQ_INSERT) ? S_APPEND : S_DONE;
                    end
                end
            end
            S_MOVE: begin
                wr_en        = 1'b1;
                wr_addr      = j_reg[AW-1:0];
                wr_data      = rd_data;
                size_next    = last_pos;
                removed_next = removed_reg + ONE_C;
                state_next   = S_RD;
            end
            S_APPEND: begin
                if (size_reg >= CAP_C) begin
                    status_next = ST_FULL;
                end else begin
                    wr_en     = 1'b1;
                    wr_addr   = size_reg[AW-1:0];
                    wr_data   = {b_reg, a_reg};
                    size_next = size_reg + ONE_C;
                end
                state_next = S_DONE;
            end
            S_FETCH: begin
                e1_next    = rd_data[OBJ_BITS-1:0];
                e2_next    = rd_data[2*OBJ_BITS-1:OBJ_BITS];
                state_next = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            size_reg  <= '0;
        end else begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
        req_reg     <= req_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        j_reg       <= j_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        e1_reg      <= e1_next;
        e2_reg      <= e2_next;
    end

    assign idle        = (state_reg == S_IDLE);
    assign point_one   = a_reg;
    assign point_two   = b_reg;
    assign res_status  = status_reg;
    assign res_count   = size_reg;
    assign res_removed = removed_reg;
    assign res_one     = e1_reg;
    assign res_two     = e2_reg;

endmodule

@@ hw/rtl/pareto_archive_insert_unit.sv @@
// Top level of the two-objective non-dominated archive with stream ports.
// Depends on pai_pkg, pai_mem, pai_cmp and pai_seq.
//
//   Channel  Direction  Contents
//   s_       in         one request: kind in tuser, point and read slot in tdata
//   m_       out        one result per request: status, counts, read entry
//
// An insert or test scans the stored entries one entry per cycle through the
// single memory read port; each removed entry adds a move and a reread.
// A clear and a read skip the scan. Reset empties the archive at once.
// A new request is taken while the previous result waits in the output register.
module pareto_archive_insert_unit #(
    parameter int CAPACITY = 256,
    parameter int OBJ_BITS = 24
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 s_tvalid,
    output logic                                                 s_tready,
    // obj_one, obj_two, read_index
    input  logic [((2*OBJ_BITS+pai_pkg::INDEX_BITS+7)/8)*8-1:0]  s_tdata,
    // req_type
    input  logic [pai_pkg::REQ_BITS-1:0]                         s_tuser,
    output logic                                                 m_tvalid,
    input  logic                                                 m_tready,
    // status, entry_count, removed_count, entry_one, entry_two
    output logic [((pai_pkg::STATUS_BITS+2*$clog2(CAPACITY+1)+2*OBJ_BITS+7)/8)*8-1:0]
                                                                 m_tdata
);
    import pai_pkg::*;

    localparam int AW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int OUT_W  = ((STATUS_BITS + 2*CW + 2*OBJ_BITS + 7) / 8) * 8;

    logic                    idle;
    logic                    start;
    logic [OBJ_BITS-1:0]     point_one, point_two;
    cmp_res_t                cmp;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [2*OBJ_BITS-1:0]   wr_data, rd_data;
    logic                    res_valid, res_ready;
    status_t                 res_status;
    logic [CW-1:0]           res_count, res_removed;
    logic [OBJ_BITS-1:0]     res_one, res_two;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]        m_tdata_reg, m_tdata_next;

    assign s_tready  = idle;
    assign start     = s_tvalid && idle;
    assign res_ready = !m_tvalid_reg || m_tready;

    pai_seq #(
        .CAPACITY (CAPACITY),
        .OBJ_BITS (OBJ_BITS),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .idle        (idle),
        .req         (req_t'(s_tuser)),
        .obj_one     (s_tdata[OBJ_BITS-1:0]),
        .obj_two     (s_tdata[2*OBJ_BITS-1:OBJ_BITS]),
        .read_index  (s_tdata[2*OBJ_BITS+INDEX_BITS-1:2*OBJ_BITS]),
        .point_one   (point_one),
        .point_two   (point_two),
        .cmp         (cmp),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_status  (res_status),
        .res_count   (res_count),
        .res_removed (res_removed),
        .res_one     (res_one),
        .res_two     (res_two)
    );

    pai_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (2*OBJ_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pai_cmp #(
        .OBJ_BITS (OBJ_BITS)
    ) u_cmp (
        .point_one (point_one),
        .point_two (point_two),
        .entry_one (rd_data[OBJ_BITS-1:0]),
        .entry_two (rd_data[2*OBJ_BITS-1:OBJ_BITS]),
        .res       (cmp)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'({res_two, res_one, res_removed, res_count,
                                    res_status});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ dv/pareto_archive_insert_unit_chk.sv @@
// Checker for the two-objective non-dominated archive: watches both stream channels,
// keeps its own copy of the archive and compares every result field by field.
// Depends on pai_pkg for the request and status codes.
module pareto_archive_insert_unit_chk
    import pai_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int OBJ_BITS = 24
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 s_tvalid,
    input  logic                                                 s_tready,
    input  logic [((2*OBJ_BITS+INDEX_BITS+7)/8)*8-1:0]           s_tdata,
    input  logic [REQ_BITS-1:0]                                  s_tuser,
    input  logic                                                 m_tvalid,
    input  logic                                                 m_tready,
    input  logic [((STATUS_BITS+2*$clog2(CAPACITY+1)+2*OBJ_BITS+7)/8)*8-1:0]
                                                                 m_tdata,
    output int                                                   mismatches,
    output int                                                   outstanding
);

    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int CNT_LO     = STATUS_BITS;
    localparam int REM_LO     = CNT_LO + COUNT_BITS;
    localparam int ONE_LO     = REM_LO + COUNT_BITS;
    localparam int TWO_LO     = ONE_LO + OBJ_BITS;

    typedef struct {
        status_t                 status;
        logic [COUNT_BITS-1:0]   entry_count;
        logic [COUNT_BITS-1:0]   removed_count;
        logic [OBJ_BITS-1:0]     entry_one;
        logic [OBJ_BITS-1:0]     entry_two;
    } archive_result_t;

    logic [OBJ_BITS-1:0] front_one [CAPACITY];
    logic [OBJ_BITS-1:0] front_two [CAPACITY];
    int unsigned         front_size = 0;
    archive_result_t     results_q[$];
    int                  fail_total = 0;
    int                  waiting    = 0;

    assign mismatches  = fail_total;
    assign outstanding = waiting;

    function automatic archive_result_t predict_request(input req_t kind,
                                                        input logic [OBJ_BITS-1:0] p1,
                                                        input logic [OBJ_BITS-1:0] p2,
                                                        input logic [INDEX_BITS-1:0] slot);
        archive_result_t res;
        int unsigned     j;
        int unsigned     removed;
        bit              dominated;
        res.status    = ST_OK;
        res.entry_one = '0;
        res.entry_two = '0;
        removed       = 0;
        dominated     = 1'b0;
        case (kind)
            REQ_INSERT: begin
                j = 0;
                while (j < front_size && !dominated) begin
                    if (p1 > front_one[j] && p2 > front_two[j]) begin
                        front_size--;
                        front_one[j] = front_one[front_size];
                        front_two[j] = front_two[front_size];
                        removed++;
                    end else if (p1 <= front_one[j] && p2 <= front_two[j]) begin
                        dominated = 1'b1;
                    end else begin
                        j++;
                    end
                end
                if (dominated) begin
                    res.status = ST_DOMINATED;
                end else if (front_size >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    front_one[front_size] = p1;
                    front_two[front_size] = p2;
                    front_size++;
                end
            end
            REQ_TEST: begin
                for (j = 0; j < front_size; j++) begin
                    if (front_one[j] >= p1 && front_two[j] >= p2) begin
                        res.status = ST_DOMINATED;
                        break;
                    end
                end
            end
            REQ_CLEAR: begin
                front_size = 0;
            end
            default: begin
                if (slot < front_size) begin
                    res.entry_one = front_one[slot];
                    res.entry_two = front_two[slot];
                end else begin
                    res.status = ST_BAD_INDEX;
                end
            end
        endcase
        res.entry_count   = COUNT_BITS'(front_size);
        res.removed_count = COUNT_BITS'(removed);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin
        archive_result_t want;
        if (!aresetn) begin
            front_size = 0;
            results_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_q.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_total++;
                end else begin
                    want = results_q.pop_front();
                    check_field("status", want.status, m_tdata[STATUS_BITS-1:0]);
                    check_field("entry_count", want.entry_count,
                                m_tdata[CNT_LO +: COUNT_BITS]);
                    check_field("removed_count", want.removed_count,
                                m_tdata[REM_LO +: COUNT_BITS]);
                    check_field("entry_one", want.entry_one, m_tdata[ONE_LO +: OBJ_BITS]);
                    check_field("entry_two", want.entry_two, m_tdata[TWO_LO +: OBJ_BITS]);
                end
            end
            if (s_tvalid && s_tready) begin
                results_q.push_back(predict_request(req_t'(s_tuser),
                                                    s_tdata[OBJ_BITS-1:0],
                                                    s_tdata[OBJ_BITS +: OBJ_BITS],
                                                    s_tdata[2*OBJ_BITS +: INDEX_BITS]));
            end
        end
        waiting = results_q.size();
    end

endmodule

@@ dv/pareto_archive_insert_unit_tb.sv @@
// Top of the archive testbench: clock, reset, request stimulus and result back-pressure.
// Depends on pai_pkg, pareto_archive_insert_unit and pareto_archive_insert_unit_chk.
module pareto_archive_insert_unit_tb;
    import pai_pkg::*;

    localparam int          CAPACITY    = 256;
    localparam int          OBJ_BITS    = 24;
    localparam int          S_BITS      = ((2*OBJ_BITS+INDEX_BITS+7)/8)*8;
    localparam int          M_BITS      = ((STATUS_BITS+2*$clog2(CAPACITY+1)+2*OBJ_BITS+7)/8)*8;
    localparam int          RANDOM_REQS = 1500;
    localparam int unsigned CYCLE_LIMIT = 12_000_000;
    localparam logic [OBJ_BITS-1:0] OBJ_MAX = '1;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_BITS-1:0]   s_tdata  = '0;
    logic [REQ_BITS-1:0] s_tuser  = REQ_INSERT;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_BITS-1:0]   m_tdata;

    int                  chk_fails;
    int                  chk_pending;
    int unsigned         cycles      = 0;
    int                  ready_stall = 0;
    bit                  hold_req    = 1'b0;
    bit                  hold_done   = 1'b0;
    bit                  no_idle     = 1'b0;

    pareto_archive_insert_unit #(
        .CAPACITY(CAPACITY),
        .OBJ_BITS(OBJ_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    pareto_archive_insert_unit_chk #(
        .CAPACITY(CAPACITY),
        .OBJ_BITS(OBJ_BITS)
    ) archive_chk (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .mismatches(chk_fails),
        .outstanding(chk_pending)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("pareto_archive_insert_unit_tb NOT OK");
            $finish;
        end
    end

    function automatic int stall_length();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom_range(20, 80);
        end
        return $urandom_range(1, 3);
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            m_tready    <= 1'b0;
        end else if (hold_req && !hold_done) begin
            ready_stall <= 399;
            hold_done   <= 1'b1;
            m_tready    <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            ready_stall <= stall_length() - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input req_t kind, input logic [OBJ_BITS-1:0] p1,
                                input logic [OBJ_BITS-1:0] p2,
                                input logic [INDEX_BITS-1:0] slot);
        int gap;
        gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : stall_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {slot, p2, p1};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge aclk);
    endtask

    task automatic pick_point(output logic [OBJ_BITS-1:0] p1, output logic [OBJ_BITS-1:0] p2);
        int unsigned mode;
        int unsigned step;
        mode = $urandom_range(0, 9);
        step = $urandom_range(0, 63);
        if (mode == 0) begin
            p1 = OBJ_BITS'($urandom);
            p2 = OBJ_BITS'($urandom);
        end else if (mode == 1) begin
            p1 = ($urandom_range(0, 1) == 0) ? OBJ_MAX : '0;
            p2 = ($urandom_range(0, 2) == 0) ? OBJ_BITS'($urandom) : OBJ_MAX;
        end else begin
            // Points near a trade-off line, so many survive and duplicates occur.
            p1 = OBJ_BITS'(step * 1000 + $urandom_range(0, 3));
            p2 = OBJ_BITS'((63 - step) * 1000 + $urandom_range(0, 3));
        end
    endtask

    task automatic random_request();
        int unsigned         pick;
        req_t                kind;
        logic [OBJ_BITS-1:0] p1;
        logic [OBJ_BITS-1:0] p2;
        logic [INDEX_BITS-1:0] slot;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            kind = REQ_INSERT;
        end else if (pick < 66) begin
            kind = REQ_TEST;
        end else if (pick < 70) begin
            kind = REQ_CLEAR;
        end else begin
            kind = REQ_READ;
        end
        pick_point(p1, p2);
        slot = ($urandom_range(0, 3) == 0) ? INDEX_BITS'($urandom_range(0, 255))
                                            : INDEX_BITS'($urandom_range(0, 40));
        send_request(kind, p1, p2, slot);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_request(REQ_READ,   '0,      '0,      '0);
        send_request(REQ_TEST,   '0,      '0,      '0);
        send_request(REQ_INSERT, '0,      '0,      '1);
        send_request(REQ_INSERT, '0,      '0,      '0);
        send_request(REQ_TEST,   '0,      '0,      '0);
        send_request(REQ_INSERT, OBJ_MAX, '0,      '0);
        send_request(REQ_INSERT, '0,      OBJ_MAX, '0);
        send_request(REQ_INSERT, 24'd1,   24'd1,   '0);
        send_request(REQ_READ,   '0,      '0,      8'd0);
        send_request(REQ_READ,   '0,      '0,      8'd1);
        send_request(REQ_READ,   '0,      '0,      8'd2);
        send_request(REQ_READ,   '0,      '0,      8'd3);
        send_request(REQ_READ,   OBJ_MAX, OBJ_MAX, '1);
        send_request(REQ_TEST,   OBJ_MAX, OBJ_MAX, '0);
        send_request(REQ_TEST,   OBJ_MAX, '0,      '0);
        send_request(REQ_CLEAR,  OBJ_MAX, OBJ_MAX, '1);
        send_request(REQ_READ,   '0,      '0,      8'd0);
        drain_results();

        // Fill the archive to capacity with points that do not dominate one another.
        for (int i = 0; i < CAPACITY; i++) begin
            send_request(REQ_INSERT, OBJ_BITS'(i), OBJ_BITS'(CAPACITY - 1 - i),
                         INDEX_BITS'($urandom));
        end
        send_request(REQ_INSERT, OBJ_MAX, '0,      '0);
        send_request(REQ_READ,   '0,      '0,      '1);
        send_request(REQ_READ,   '0,      '0,      '0);
        send_request(REQ_TEST,   '0,      '0,      '0);
        send_request(REQ_INSERT, 24'd100, 24'd100, '0);
        send_request(REQ_INSERT, OBJ_MAX, OBJ_MAX, '0);
        send_request(REQ_READ,   '0,      '0,      '0);
        drain_results();

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == 100) begin
                hold_req <= 1'b1;
            end
            no_idle <= (n % 300) >= 250;
            if (n == RANDOM_REQS / 2) begin
                drain_results();
            end
            random_request();
        end

        drain_results();
        repeat (800) @(negedge aclk);
        if (chk_fails == 0) begin
            $display("pareto_archive_insert_unit_tb OK");
        end else begin
            $display("pareto_archive_insert_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ pareto_archive_insert_unit.f @@
hw/rtl/pai_pkg.sv
hw/rtl/pai_mem.sv
hw/rtl/pai_cmp.sv
hw/rtl/pai_seq.sv
hw/rtl/pareto_archive_insert_unit.sv
dv/pareto_archive_insert_unit_chk.sv
dv/pareto_archive_insert_unit_tb.sv
